[rtl/voxel_column_store_core_assert.svh]
// ----------------------------------------------------------------------------
// Voxel column store assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_COLUMN_STORE_CORE_ASSERT_SVH
`define VOXEL_COLUMN_STORE_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define VCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition on one edge implies another on the next edge
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/vcs_pkg.sv]
// ----------------------------------------------------------------------------
// Voxel column store package
// Shared widths, item kinds and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vcs_pkg;

   // Default volume size and scan start
   localparam int STORE_DEPTH_DEF = 65536;
   localparam int SCAN_TOP_DEF    = 127;

   // Field widths
   localparam int POS_W   = 16;
   localparam int ID_W    = 8;
   localparam int META_W  = 4;
   localparam int COORD_W = 4;
   localparam int Y_W     = 8;
   localparam int TOPY_W  = 7;
   localparam int CELL_W  = ID_W + META_W;
   localparam int KIND_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // Item kinds carried on req_tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_SCAN  = 2'd2
   } kind_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_en;      // write zero at the clear pointer and advance it
      logic take;        // word accepted on the request channel
      logic scan_issue;  // read the next y of the column
      logic load_read;   // load the response register from a read
      logic load_scan;   // load the response register from a scan
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     clear_last;
      logic     scan_hit;
      logic     scan_last;
   } dp_status_type;

endpackage

[rtl/vcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Voxel column store controller
// Sequences the clearing pass, single-word reads and writes, and the column
// scan; owns the request ready and response valid.
// ----------------------------------------------------------------------------
module vcs_ctrl import vcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   `include "voxel_column_store_core_assert.svh"

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN_FILL,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   // Take a word only when idle and the response register is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               cmd.take = 1'b1;
               case (status.kind)
                  KIND_READ: state_in = ST_READ;
                  KIND_SCAN: state_in = ST_SCAN_FILL;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN_FILL: begin
            cmd.scan_issue = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_hit || status.scan_last) begin
               cmd.load_scan = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response valid until the word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_read || cmd.load_scan) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response register is always empty when a new result lands
   `VCS_ASSERT(a_load_free, ((cmd.load_read || cmd.load_scan) |-> !rsp_valid_ff), "response overwritten")
   // No word accepted during the clearing pass
   `VCS_ASSERT(a_clear_block, ((state_ff == ST_CLEAR) |-> !req_tready), "accept during clear")
   // A read result is presented once the read has passed from ST_READ into the response valid register
   `VCS_ASSERT(a_read_lat, ((req_accept && status.kind == KIND_READ) |-> ##2 rsp_valid_ff), "read result late")
   // A scan always begins by filling the read pipe
   `VCS_ASSERT_NEXT(a_scan_fill, (req_accept && status.kind == KIND_SCAN), (state_ff == ST_SCAN_FILL), "scan did not start")

endmodule

[rtl/vcs_datapath.sv]
// ----------------------------------------------------------------------------
// Voxel column store datapath
// Holds the voxel memory, the clear pointer, the scan counters, the air id
// register and the response register.
// ----------------------------------------------------------------------------
module vcs_datapath import vcs_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int SCAN_TOP    = SCAN_TOP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  csr_valid,
   input  logic [ID_W-1:0]       csr_data,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [POS_W:0]    DEPTH_LIM = (POS_W + 1)'(STORE_DEPTH);
   localparam logic [Y_W-1:0]    Y_START   = Y_W'(SCAN_TOP);

   // Request fields
   logic [POS_W-1:0]   req_pos;
   logic [ID_W-1:0]    req_id;
   logic [META_W-1:0]  req_meta;
   logic [COORD_W-1:0] req_col_x;
   logic [COORD_W-1:0] req_col_z;

   assign req_pos   = req_tdata[15:0];
   assign req_id    = req_tdata[23:16];
   assign req_meta  = req_tdata[27:24];
   assign req_col_x = req_tdata[31:28];
   assign req_col_z = req_tdata[35:32];

   logic [CELL_W-1:0]  store_mem [STORE_DEPTH];
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [ID_W-1:0]    air_id_ff, air_id_in;
   logic [COORD_W-1:0] col_x_ff, col_z_ff;
   logic [Y_W-1:0]     scan_y_ff, chk_y_ff;
   logic [CELL_W-1:0]  rd_data_ff;
   logic               rd_oor_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [POS_W-1:0]   full_addr;
   logic               addr_ok;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic [CELL_W-1:0]  mem_wdata;
   logic [ID_W-1:0]    rd_id;
   logic [META_W-1:0]  rd_meta;

   // Select the memory address: clear pointer, scan column or request position
   always_comb begin
      full_addr = cmd.scan_issue ? {col_x_ff, col_z_ff, scan_y_ff} : req_pos;
      addr_ok   = {1'b0, full_addr} < DEPTH_LIM;
      mem_addr  = full_addr[ADDR_W-1:0];
      mem_we    = cmd.take && (req_tuser == KIND_WRITE) && addr_ok;
      mem_wdata = {req_id, req_meta};
      if (cmd.clr_en) begin
         addr_ok   = 1'b1;
         mem_addr  = clr_addr_ff;
         mem_we    = 1'b1;
         mem_wdata = '0;
      end
   end

   // Voxel memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_addr];
      rd_oor_ff  <= !addr_ok;
   end

   // Positions beyond the store read as zero
   assign rd_id   = rd_oor_ff ? '0 : rd_data_ff[CELL_W-1:META_W];
   assign rd_meta = rd_oor_ff ? '0 : rd_data_ff[META_W-1:0];

   // Advance the clear pointer; take air id writes
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_en) begin
         clr_addr_in = (clr_addr_ff == CLR_LAST) ? '0 : clr_addr_ff + 1'b1;
      end
      air_id_in = csr_valid ? csr_data : air_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         air_id_ff   <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         air_id_ff   <= air_id_in;
      end
   end

   // Latch the column and step y downward, one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         col_x_ff  <= req_col_x;
         col_z_ff  <= req_col_z;
         scan_y_ff <= Y_START;
      end else if (cmd.scan_issue) begin
         scan_y_ff <= scan_y_ff - 1'b1;
      end
      if (cmd.scan_issue) begin
         chk_y_ff <= scan_y_ff;
      end
   end

   // Load the response word
   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         rsp_data_ff <= {1'b0, TOPY_W'(0), rd_id, rd_meta, rd_meta, rd_id};
      end else if (cmd.load_scan) begin
         rsp_data_ff <= {1'b0, chk_y_ff[TOPY_W-1:0], (RSP_DATA_W - TOPY_W - 1)'(0)};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // Status toward the controller
   assign status.kind       = kind_type'(req_tuser);
   assign status.clear_last = (clr_addr_ff == CLR_LAST);
   assign status.scan_hit   = (rd_id != air_id_ff);
   assign status.scan_last  = (chk_y_ff == '0);

endmodule

[rtl/voxel_column_store_core.sv]
// ----------------------------------------------------------------------------
// Voxel column store core
// 16x256x16 voxel volume of block ids and metadata with write, read and
// column top scan items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | tvalid / tready   | tdata: position, id, meta, column; tuser: kind
//  rsp     | out       | tvalid / tready   | tdata: id, meta, packed state, top y
//  csr     | in        | valid / ready     | data: air id
//
//  After reset a clearing pass zeroes all STORE_DEPTH entries of the memory,
//  one entry a cycle; no request word is taken meanwhile, csr writes are.
//  A write is stored when taken; a read answers from the registered memory read.
//  A scan steps y down from SCAN_TOP, reading the single memory port once per
//  y, until it finds an id other than the air id or reaches y zero.
//  One item is in work at a time; a response word that waits and is not
//  being taken holds off the next request word.
// ----------------------------------------------------------------------------
module voxel_column_store_core import vcs_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int SCAN_TOP    = SCAN_TOP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pos[15:0], block_id[23:16], meta[27:24], col_x[31:28], col_z[35:32], zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // read_id[7:0], read_meta[11:8], packed_state[23:12], top_y[30:24], zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ID_W-1:0]       csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Air id writes are always taken
   assign csr_ready = 1'b1;

   vcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vcs_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .SCAN_TOP    (SCAN_TOP)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
